/* hw/rtl/ahbp_pkg.sv */
// Shared types, widths and constants for the horizon band peak unit.
`default_nettype none

package ahbp_pkg;

  // Block dimensions
  localparam int MaxChannels = 8;
  localparam int NumBands    = 4;
  localparam int LenFields   = 4;

  // Field widths
  localparam int SampleW  = 16;
  localparam int PosW     = 15;
  localparam int ChannelW = 3;
  localparam int GainW    = 16;
  localparam int HeightW  = 10;
  localparam int CountW   = 3;
  localparam int ChanIdxW = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;

  // Arithmetic widths: |peak| * gain * height >> 23
  localparam int MagW       = SampleW + 1;
  localparam int ProdW      = MagW + GainW;
  localparam int MulW       = ProdW + GainW;
  localparam int ScaleShift = 23;
  localparam int ScaledW    = ProdW + HeightW - ScaleShift;
  localparam int BandCntW   = $clog2(NumBands + 1);
  localparam int LimW       = HeightW + BandCntW;
  localparam int RemW       = LimW + 1;
  localparam int BandIdxW   = (NumBands > 1) ? $clog2(NumBands) : 1;

  // Configuration register indexes and reset values
  localparam int CfgIdxW = 1;
  localparam logic [CfgIdxW-1:0] CfgAmplitudeGain = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBandHeight    = 1'b1;
  localparam logic [GainW-1:0]   GainReset        = 16'd256;
  localparam logic [HeightW-1:0] HeightReset      = 10'd64;

  // Band engine sequencer
  typedef enum logic [2:0] {
    ENG_IDLE,
    ENG_MUL_GAIN,
    ENG_MUL_HEIGHT,
    ENG_SPLIT,
    ENG_DONE
  } eng_state_t;

  // One column result, low side and high side
  typedef struct packed {
    logic [CountW-1:0]                low_count;
    logic [LenFields-1:0][HeightW-1:0] low_len;
    logic [CountW-1:0]                high_count;
    logic [LenFields-1:0][HeightW-1:0] high_len;
  } band_result_t;

endpackage

`default_nettype wire

/* hw/rtl/ahbp_band_engine.sv */
// Scaling and band split of one column's peaks on a shared multiplier and subtractor.
`default_nettype none

module ahbp_band_engine (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [ahbp_pkg::MagW-1:0]     neg_mag,
  input  wire logic [ahbp_pkg::MagW-1:0]     pos_mag,
  input  wire logic [ahbp_pkg::GainW-1:0]    gain,
  input  wire logic [ahbp_pkg::HeightW-1:0]  height,
  input  wire logic                          take,
  output logic                               busy,
  output logic                               done,
  output ahbp_pkg::band_result_t             result
);
  import ahbp_pkg::*;

  eng_state_t state, state_next;

  logic                      side;      // 0: negative peak, 1: positive peak
  logic [BandIdxW-1:0]       band;
  logic signed [RemW-1:0]    rem;
  logic [ProdW-1:0]          prod;
  logic [MagW-1:0]           mag_neg;
  logic [MagW-1:0]           mag_pos;
  logic [BandCntW-1:0]       count [2];
  logic [HeightW-1:0]        lens  [2][LenFields];

  logic [ProdW-1:0]          mul_a;
  logic [GainW-1:0]          mul_b;
  logic [MulW-1:0]           mul_p;
  logic [ScaledW-1:0]        scaled;
  logic [LimW-1:0]           lim;
  logic [LimW-1:0]           clamped;
  logic signed [RemW-1:0]    h_rem;
  logic signed [RemW-1:0]    diff;
  logic [HeightW-1:0]        len_val;
  logic                      stop;
  logic                      last;

  // Shared multiplier: mag * gain first, then that product * height
  always_comb begin
    if (state == ENG_MUL_GAIN) begin
      mul_a = ProdW'(side ? mag_pos : mag_neg);
      mul_b = gain;
    end else begin
      mul_a = prod;
      mul_b = GainW'(height);
    end
    mul_p = MulW'(mul_a) * MulW'(mul_b);
  end

  // Scale and clamp to the full stack height
  assign scaled  = mul_p[ScaleShift +: ScaledW];
  assign lim     = LimW'(height * NumBands);
  assign clamped = (scaled > ScaledW'(lim)) ? lim : LimW'(scaled);

  // Shared subtractor for the band split
  assign h_rem   = $signed({{(RemW-HeightW){1'b0}}, height});
  assign diff    = rem - h_rem;
  assign len_val = (rem > h_rem) ? height : rem[HeightW-1:0];
  assign stop    = side ? (rem <= 0) : (rem < 0);
  assign last    = (band == BandIdxW'(NumBands - 1));

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ENG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ENG_IDLE:       if (start) state_next = ENG_MUL_GAIN;
      ENG_MUL_GAIN:   state_next = ENG_MUL_HEIGHT;
      ENG_MUL_HEIGHT: state_next = ENG_SPLIT;
      ENG_SPLIT: begin
        if (stop || last) state_next = side ? ENG_DONE : ENG_MUL_GAIN;
      end
      ENG_DONE:       if (take) state_next = ENG_IDLE;
      default:        state_next = ENG_IDLE;
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      ENG_IDLE: begin
        if (start) begin
          mag_neg <= neg_mag;
          mag_pos <= pos_mag;
          side    <= 1'b0;
          for (int s = 0; s < 2; s++) begin
            count[s] <= '0;
            for (int i = 0; i < LenFields; i++) lens[s][i] <= '0;
          end
        end
      end
      ENG_MUL_GAIN: begin
        prod <= mul_p[ProdW-1:0];
      end
      ENG_MUL_HEIGHT: begin
        rem  <= $signed({1'b0, clamped});
        band <= '0;
      end
      ENG_SPLIT: begin
        if (!stop) begin
          if (int'(band) < LenFields) lens[side][band] <= len_val;
          count[side] <= count[side] + BandCntW'(1);
          rem         <= diff;
          band        <= band + BandIdxW'(1);
        end
        if (stop || last) side <= 1'b1;
      end
      default: ;
    endcase
  end

  assign busy = (state != ENG_IDLE);
  assign done = (state == ENG_DONE);

  // Result view; counts are reported modulo eight
  always_comb begin
    result.low_count  = count[0][CountW-1:0];
    result.high_count = count[1][CountW-1:0];
    for (int i = 0; i < LenFields; i++) begin
      result.low_len[i]  = lens[0][i];
      result.high_len[i] = lens[1][i];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/audio_horizon_band_peaks_unit.sv */
// Top level of the horizon band peak unit: peak store, config and result register.
//
// Sample channel: sample, channel and column_end move on sample_valid when
// sample_stall is low. Each beat folds the sample into the channel's positive
// or negative peak. A beat with column_end set also starts the
// band engine, which scales both peaks on one shared multiplier (two passes
// per peak) and splits each into bands on one subtractor, one band a cycle.
// That channel's peaks return to zero at once.
// Result channel: one beat per column_end beat, held in an output register on
// result_valid until result_stall is low.
// Column flow: for each side, negative first, the engine multiplies by gain, then by
// height, then splits into bands; an engine hand-over state follows before
// result_valid. sample_stall is high while the engine runs; a stalled result
// keeps the engine waiting with it.
// Reset: all peaks clear to zero, gain returns to 1.0 (256), band height to 64,
// no result pending. Configuration writes take effect at once; write only
// while no column is in flight.
`default_nettype none

module audio_horizon_band_peaks_unit (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [ahbp_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [ahbp_pkg::GainW-1:0]    cfg_data,
  // sample channel
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire logic signed [ahbp_pkg::SampleW-1:0] sample,
  input  wire logic [ahbp_pkg::ChannelW-1:0] channel,
  input  wire logic                          column_end,
  // result channel
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output logic [ahbp_pkg::ChannelW-1:0]      out_channel,
  output logic [ahbp_pkg::CountW-1:0]        low_count,
  output logic [ahbp_pkg::HeightW-1:0]       low_len0,
  output logic [ahbp_pkg::HeightW-1:0]       low_len1,
  output logic [ahbp_pkg::HeightW-1:0]       low_len2,
  output logic [ahbp_pkg::HeightW-1:0]       low_len3,
  output logic [ahbp_pkg::CountW-1:0]        high_count,
  output logic [ahbp_pkg::HeightW-1:0]       high_len0,
  output logic [ahbp_pkg::HeightW-1:0]       high_len1,
  output logic [ahbp_pkg::HeightW-1:0]       high_len2,
  output logic [ahbp_pkg::HeightW-1:0]       high_len3
);
  import ahbp_pkg::*;

  logic [GainW-1:0]           amplitude_gain;
  logic [HeightW-1:0]         band_height;

  logic signed [SampleW-1:0]  neg_peak [MaxChannels];
  logic [PosW-1:0]            pos_peak [MaxChannels];

  logic [ChanIdxW-1:0]        idx;
  logic                       ch_ok;
  logic                       accept;
  logic signed [SampleW-1:0]  neg_cur;
  logic [PosW-1:0]            pos_cur;
  logic signed [SampleW-1:0]  neg_new;
  logic [PosW-1:0]            pos_new;
  logic [MagW-1:0]            neg_mag;
  logic [MagW-1:0]            pos_mag;

  logic                       eng_busy;
  logic                       eng_done;
  logic                       eng_take;
  band_result_t               eng_result;
  band_result_t               result;
  logic [ChannelW-1:0]        pend_channel;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_gain <= GainReset;
      band_height    <= HeightReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgAmplitudeGain: amplitude_gain <= cfg_data;
        CfgBandHeight:    band_height    <= cfg_data[HeightW-1:0];
        default: ;
      endcase
    end
  end

  // Peak fold for the incoming beat
  assign idx          = channel[ChanIdxW-1:0];
  assign ch_ok        = (int'(channel) < MaxChannels);
  assign sample_stall = eng_busy;
  assign accept       = sample_valid && !sample_stall && ch_ok;
  assign neg_cur      = neg_peak[idx];
  assign pos_cur      = pos_peak[idx];

  always_comb begin
    neg_new = neg_cur;
    pos_new = pos_cur;
    if (sample > 0) begin
      if (sample[PosW-1:0] > pos_cur) pos_new = sample[PosW-1:0];
    end else begin
      if (sample < neg_cur) neg_new = sample;
    end
    neg_mag = MagW'(0) - MagW'(neg_new);
    pos_mag = MagW'(pos_new);
  end

  // Peak store: cleared at reset and after each column end
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < MaxChannels; c++) begin
        neg_peak[c] <= '0;
        pos_peak[c] <= '0;
      end
    end else if (accept) begin
      if (column_end) begin
        neg_peak[idx] <= '0;
        pos_peak[idx] <= '0;
      end else begin
        neg_peak[idx] <= neg_new;
        pos_peak[idx] <= pos_new;
      end
    end
  end

  // Channel of the column in flight
  always_ff @(posedge clk) begin
    if (accept && column_end) pend_channel <= channel;
  end

  ahbp_band_engine u_engine (
    .clk     (clk),
    .rst     (rst),
    .start   (accept && column_end),
    .neg_mag (neg_mag),
    .pos_mag (pos_mag),
    .gain    (amplitude_gain),
    .height  (band_height),
    .take    (eng_take),
    .busy    (eng_busy),
    .done    (eng_done),
    .result  (eng_result)
  );

  // Output register: loads when empty or being drained
  assign eng_take = eng_done && (!result_valid || !result_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (eng_take) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take) begin
      result      <= eng_result;
      out_channel <= pend_channel;
    end
  end

  assign low_count  = result.low_count;
  assign low_len0   = result.low_len[0];
  assign low_len1   = result.low_len[1];
  assign low_len2   = result.low_len[2];
  assign low_len3   = result.low_len[3];
  assign high_count = result.high_count;
  assign high_len0  = result.high_len[0];
  assign high_len1  = result.high_len[1];
  assign high_len2  = result.high_len[2];
  assign high_len3  = result.high_len[3];

endmodule

`default_nettype wire

/* test/band_peaks_checker.sv */
// Checker for the horizon band peak unit: predicts column results and compares each beat.
`default_nettype none

module band_peaks_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_we,
  input  wire logic [ahbp_pkg::CfgIdxW-1:0]        cfg_index,
  input  wire logic [ahbp_pkg::GainW-1:0]          cfg_data,
  input  wire logic                                sample_valid,
  input  wire logic                                sample_stall,
  input  wire logic signed [ahbp_pkg::SampleW-1:0] sample,
  input  wire logic [ahbp_pkg::ChannelW-1:0]       channel,
  input  wire logic                                column_end,
  input  wire logic                                result_valid,
  input  wire logic                                result_stall,
  input  wire logic [ahbp_pkg::ChannelW-1:0]       out_channel,
  input  wire logic [ahbp_pkg::CountW-1:0]         low_count,
  input  wire logic [ahbp_pkg::HeightW-1:0]        low_len0,
  input  wire logic [ahbp_pkg::HeightW-1:0]        low_len1,
  input  wire logic [ahbp_pkg::HeightW-1:0]        low_len2,
  input  wire logic [ahbp_pkg::HeightW-1:0]        low_len3,
  input  wire logic [ahbp_pkg::CountW-1:0]         high_count,
  input  wire logic [ahbp_pkg::HeightW-1:0]        high_len0,
  input  wire logic [ahbp_pkg::HeightW-1:0]        high_len1,
  input  wire logic [ahbp_pkg::HeightW-1:0]        high_len2,
  input  wire logic [ahbp_pkg::HeightW-1:0]        high_len3,
  output int                                       mismatches,
  output int                                       columns_due
);
  timeunit 1ns;
  timeprecision 1ps;

  import ahbp_pkg::*;

  // One side of a column: band count and packed segment lengths, band 0 lowest
  typedef struct packed {
    logic [CountW-1:0]            count;
    logic [LenFields*HeightW-1:0] len;
  } side_t;

  typedef struct packed {
    logic [ChannelW-1:0]          chan;
    logic [CountW-1:0]            low_count;
    logic [LenFields*HeightW-1:0] low_len;
    logic [CountW-1:0]            high_count;
    logic [LenFields*HeightW-1:0] high_len;
  } column_bands_t;

  // Predictor state and configuration copy
  logic [GainW-1:0]          gain_reg;
  logic [HeightW-1:0]        height_reg;
  logic signed [SampleW-1:0] low_peak [MaxChannels];
  logic [PosW-1:0]           high_peak [MaxChannels];
  column_bands_t             pending_columns [$];

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $time, msg);
    mismatches++;
  endtask

  // |peak| * gain * height / 2^23, truncated, clamped to the full band stack
  function automatic longint scale_peak(input longint mag);
    longint v;
    longint lim;
    v = (mag * gain_reg * height_reg) >> ScaleShift;
    lim = height_reg * NumBands;
    if (v > lim) v = lim;
    return v;
  endfunction

  // Cut a scaled magnitude into stacked bands; the low side also draws on r == 0
  function automatic side_t split_peak(input longint m, input bit allow_zero);
    side_t  s;
    longint r;
    longint h;
    int     cnt;
    s = '0;
    r = m;
    h = height_reg;
    cnt = 0;
    for (int b = 0; b < NumBands; b++) begin
      if (allow_zero ? (r < 0) : (r <= 0)) break;
      if (b < LenFields) s.len[b*HeightW +: HeightW] = (r > h) ? h[HeightW-1:0] : r[HeightW-1:0];
      cnt++;
      r -= h;
    end
    s.count = cnt[CountW-1:0];
    return s;
  endfunction

  // Fold an accepted sample beat; a column end queues its band result
  task automatic fold_sample(input logic signed [SampleW-1:0] s,
                             input logic [ChannelW-1:0] ch, input logic last);
    column_bands_t col;
    side_t         lo;
    side_t         hi;
    longint        low_mag;
    longint        high_mag;
    if (ch >= MaxChannels) return;
    if (s > 0) begin
      if (s[PosW-1:0] > high_peak[ch]) high_peak[ch] = s[PosW-1:0];
    end else if (s < low_peak[ch]) begin
      low_peak[ch] = s;
    end
    if (!last) return;
    low_mag = low_peak[ch];
    low_mag = -low_mag;
    high_mag = high_peak[ch];
    lo = split_peak(scale_peak(low_mag), 1'b1);
    hi = split_peak(scale_peak(high_mag), 1'b0);
    col.chan = ch;
    col.low_count = lo.count;
    col.low_len = lo.len;
    col.high_count = hi.count;
    col.high_len = hi.len;
    pending_columns.push_back(col);
    low_peak[ch] = '0;
    high_peak[ch] = '0;
  endtask

  // Compare an accepted result beat with the oldest pending column
  task automatic check_result();
    column_bands_t                want;
    logic [LenFields*HeightW-1:0] got_low;
    logic [LenFields*HeightW-1:0] got_high;
    got_low = {low_len3, low_len2, low_len1, low_len0};
    got_high = {high_len3, high_len2, high_len1, high_len0};
    if (pending_columns.size() == 0) begin
      report_mismatch($sformatf("result beat for channel %0d with no column pending",
                                out_channel));
      return;
    end
    want = pending_columns.pop_front();
    if (out_channel !== want.chan)
      report_mismatch($sformatf("out_channel got %0d expected %0d", out_channel, want.chan));
    if (low_count !== want.low_count)
      report_mismatch($sformatf("ch %0d low_count got %0d expected %0d",
                                want.chan, low_count, want.low_count));
    if (high_count !== want.high_count)
      report_mismatch($sformatf("ch %0d high_count got %0d expected %0d",
                                want.chan, high_count, want.high_count));
    for (int b = 0; b < LenFields; b++) begin
      if (got_low[b*HeightW +: HeightW] !== want.low_len[b*HeightW +: HeightW])
        report_mismatch($sformatf("ch %0d low_len%0d got %0d expected %0d", want.chan, b,
                                  got_low[b*HeightW +: HeightW],
                                  want.low_len[b*HeightW +: HeightW]));
      if (got_high[b*HeightW +: HeightW] !== want.high_len[b*HeightW +: HeightW])
        report_mismatch($sformatf("ch %0d high_len%0d got %0d expected %0d", want.chan, b,
                                  got_high[b*HeightW +: HeightW],
                                  want.high_len[b*HeightW +: HeightW]));
    end
  endtask

  // Watch config writes and both channels at each rising edge
  always @(posedge clk) begin
    if (rst) begin
      gain_reg = GainReset;
      height_reg = HeightReset;
      for (int c = 0; c < MaxChannels; c++) begin
        low_peak[c] = '0;
        high_peak[c] = '0;
      end
      pending_columns.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CfgAmplitudeGain) gain_reg = cfg_data;
        else if (cfg_index == CfgBandHeight) height_reg = cfg_data[HeightW-1:0];
      end
      if (result_valid && !result_stall) check_result();
      if (sample_valid && !sample_stall) fold_sample(sample, channel, column_end);
    end
    columns_due <= pending_columns.size();
  end

endmodule

`default_nettype wire

/* test/tb.sv */
// Testbench top for the horizon band peak unit: clock, reset, stimulus and verdict.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ahbp_pkg::*;

  logic                       clk;
  logic                       rst;
  logic                       cfg_we;
  logic [CfgIdxW-1:0]         cfg_index;
  logic [GainW-1:0]           cfg_data;
  logic                       sample_valid;
  logic                       sample_stall;
  logic signed [SampleW-1:0]  sample;
  logic [ChannelW-1:0]        channel;
  logic                       column_end;
  logic                       result_valid;
  logic                       result_stall;
  logic [ChannelW-1:0]        out_channel;
  logic [CountW-1:0]          low_count;
  logic [HeightW-1:0]         low_len0, low_len1, low_len2, low_len3;
  logic [CountW-1:0]          high_count;
  logic [HeightW-1:0]         high_len0, high_len1, high_len2, high_len3;
  int                         mismatches;
  int                         columns_due;

  // Both sides stop idling while calm; pressure_now asks for one long result hold-off
  bit calm;
  bit pressure_now;
  bit held_off;

  localparam int PhaseItems = 120;
  localparam int NumPhases  = 8;
  localparam int HoldCycles = 400;

  audio_horizon_band_peaks_unit DUT (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample(sample), .channel(channel), .column_end(column_end),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_channel(out_channel), .low_count(low_count),
    .low_len0(low_len0), .low_len1(low_len1), .low_len2(low_len2), .low_len3(low_len3),
    .high_count(high_count),
    .high_len0(high_len0), .high_len1(high_len1), .high_len2(high_len2),
    .high_len3(high_len3)
  );

  band_peaks_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample(sample), .channel(channel), .column_end(column_end),
    .result_valid(result_valid), .result_stall(result_stall),
    .out_channel(out_channel), .low_count(low_count),
    .low_len0(low_len0), .low_len1(low_len1), .low_len2(low_len2), .low_len3(low_len3),
    .high_count(high_count),
    .high_len0(high_len0), .high_len1(high_len1), .high_len2(high_len2),
    .high_len3(high_len3),
    .mismatches(mismatches), .columns_due(columns_due)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Result side: random stalls, one long hold-off on request
  initial begin
    result_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_now && !held_off) begin
        held_off = 1'b1;
        result_stall <= 1'b1;
        repeat (HoldCycles) @(posedge clk);
      end else begin
        result_stall <= calm ? 1'b0 : ($urandom_range(99) < 29);
      end
    end
  end

  // Sample values weighted towards the extremes and small magnitudes
  function automatic logic signed [SampleW-1:0] pick_sample();
    logic signed [SampleW-1:0] v;
    case ($urandom_range(9))
      0: v = 16'sh8000;
      1: v = 16'sh7FFF;
      2: v = '0;
      3: v = SampleW'($urandom_range(1, 64));
      4: begin
        v = SampleW'($urandom_range(1, 64));
        v = -v;
      end
      default: v = SampleW'($urandom());
    endcase
    return v;
  endfunction

  // Offer one sample beat and hold it until accepted, with a random gap first
  task automatic send_beat(input logic signed [SampleW-1:0] s,
                           input logic [ChannelW-1:0] ch, input logic last);
    if (!calm && $urandom_range(99) < 29) begin
      sample_valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample <= s;
    channel <= ch;
    column_end <= last;
    do @(posedge clk); while (sample_stall);
  endtask

  // Drain every pending column, let the engine settle, then write both registers
  task automatic program_setting(input logic [GainW-1:0] gain,
                                 input logic [HeightW-1:0] height);
    sample_valid <= 1'b0;
    do @(posedge clk); while (columns_due != 0);
    repeat (16) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CfgAmplitudeGain;
    cfg_data <= gain;
    @(posedge clk);
    cfg_index <= CfgBandHeight;
    cfg_data <= {{(GainW-HeightW){1'b0}}, height};
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [GainW-1:0]   gain;
    logic [HeightW-1:0] height;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = CfgAmplitudeGain;
    cfg_data = '0;
    sample_valid = 1'b0;
    sample = '0;
    channel = '0;
    column_end = 1'b0;
    calm = 1'b0;
    pressure_now = 1'b0;
    held_off = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset setting: zero peak, full-scale negative, near full-scale positive, then mixed and unit peaks
    send_beat(16'sd0, 3'd0, 1'b1);
    send_beat(-16'sd32768, 3'd1, 1'b1);
    send_beat(16'sd32767, 3'd2, 1'b1);
    send_beat(16'sd100, 3'd3, 1'b0);
    send_beat(-16'sd200, 3'd3, 1'b0);
    send_beat(16'sd5000, 3'd3, 1'b0);
    send_beat(-16'sd30000, 3'd3, 1'b0);
    send_beat(16'sd0, 3'd3, 1'b1);
    send_beat(16'sd1, 3'd4, 1'b1);
    send_beat(-16'sd1, 3'd5, 1'b1);
    send_beat(16'sd20000, 3'd7, 1'b0);
    send_beat(-16'sd9000, 3'd7, 1'b1);

    // Maximum gain and height: full-scale peaks clamp to four bands
    program_setting(16'hFFFF, 10'd1023);
    send_beat(-16'sd32768, 3'd0, 1'b1);
    send_beat(16'sd32767, 3'd1, 1'b1);
    send_beat(-16'sd1, 3'd2, 1'b1);

    // Zero gain, minimum height: every magnitude scales to nothing
    program_setting(16'h0000, 10'd1);
    send_beat(-16'sd32768, 3'd6, 1'b1);
    send_beat(16'sd32767, 3'd6, 1'b1);

    // Gain 4.0, height 1: on the low side an exact multiple of the height draws an extra empty band
    program_setting(16'd1024, 10'd1);
    send_beat(-16'sd8192, 3'd0, 1'b1);
    send_beat(16'sd8192, 3'd1, 1'b1);
    send_beat(16'sd16384, 3'd2, 1'b0);
    send_beat(-16'sd16384, 3'd2, 1'b1);

    // Random phases, each under its own setting
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin gain = GainReset; height = HeightReset; end
        1: begin gain = 16'hFFFF; height = 10'd1023; end
        2: begin gain = 16'd1024; height = 10'd1; end
        3: begin gain = 16'd256; height = 10'd1023; end
        4: begin gain = 16'd0; height = HeightW'($urandom_range(1, 1023)); end
        default: begin
          gain = GainW'($urandom_range(0, 16'hFFFF));
          height = HeightW'($urandom_range(1, 1023));
        end
      endcase
      program_setting(gain, height);
      calm = (p == 5);
      for (int i = 0; i < PhaseItems; i++) begin
        if (p == 2 && i == 40) pressure_now = 1'b1;
        send_beat(pick_sample(), ChannelW'($urandom_range(0, MaxChannels - 1)),
                  $urandom_range(3) == 0);
      end
      calm = 1'b0;
    end

    // Drain and give the verdict
    sample_valid <= 1'b0;
    do @(posedge clk); while (columns_due != 0);
    repeat (20) @(posedge clk);
    if (mismatches == 0 && columns_due == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/ahbp_pkg.sv
hw/rtl/ahbp_band_engine.sv
hw/rtl/audio_horizon_band_peaks_unit.sv
test/band_peaks_checker.sv
test/tb.sv
